@@ design/pulse_width_manchester_frame_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pulse-width Manchester frame decoder
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_MANCHESTER_FRAME_DECODER_ASSERT_SVH
`define PULSE_WIDTH_MANCHESTER_FRAME_DECODER_ASSERT_SVH

// Condition holds at every edge
`define PWMFD_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("pwmfd: invariant violated");

// Consequent holds in the cycle after the antecedent
`define PWMFD_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("pwmfd: next-cycle check failed");

`endif

@@ design/pwmfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pwmfd_pkg
// Shared widths, codes and types of the pulse-width Manchester frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pwmfd_pkg;

	// Widths
	localparam int DUR_W      = 15;
	localparam int FRAME_BITS = 34;
	localparam int DATA_BITS  = FRAME_BITS - 2;
	localparam int HALF_N     = 2 * FRAME_BITS;
	localparam int CNT_W      = $clog2(HALF_N + 3);
	localparam int TYPE_LSB   = 29;
	localparam int CFG_IDX_W  = 3;

	// Register reset values
	localparam logic [DUR_W-1:0] HALF_MIN_RST = DUR_W'(380);
	localparam logic [DUR_W-1:0] HALF_MAX_RST = DUR_W'(620);
	localparam logic [DUR_W-1:0] FULL_MIN_RST = DUR_W'(880);
	localparam logic [DUR_W-1:0] FULL_MAX_RST = DUR_W'(1120);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HALF_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLAVE    = 3'd4;

	// Sticky error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_GLITCH = 2'd1;
	localparam logic [1:0] ERR_TIMING = 2'd2;

	// Frame status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_GLITCH = 3'd1;
	localparam logic [2:0] ST_TIMING = 3'd2;
	localparam logic [2:0] ST_START  = 3'd3;
	localparam logic [2:0] ST_PARITY = 3'd4;
	localparam logic [2:0] ST_TYPE   = 3'd5;

	// Captured frame handed to the decoder: newest half-bit in bit 0
	typedef struct packed {
		logic [HALF_N-1:0] sr;
		logic [CNT_W-1:0]  cnt;
		logic [1:0]        err;
	} snap_t;

endpackage

`default_nettype wire

@@ design/pwmfd_ifs.sv @@
// ----------------------------------------------------------------------------
// pwmfd channel interfaces
// Segment input, frame result and register write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pwmfd_seg_if;
	logic                         valid;
	logic                         ready;
	logic                         segment_level;
	logic [pwmfd_pkg::DUR_W-1:0]  segment_duration;
	logic                         frame_end;

	modport source(output valid, output segment_level, output segment_duration,
		output frame_end, input ready);
	modport sink(input valid, input segment_level, input segment_duration,
		input frame_end, output ready);
endinterface

interface pwmfd_frame_if;
	logic                                valid;
	logic                                ready;
	logic [pwmfd_pkg::DATA_BITS-1:0]     frame_word;
	logic [2:0]                          frame_status;

	modport source(output valid, output frame_word, output frame_status, input ready);
	modport sink(input valid, input frame_word, input frame_status, output ready);
endinterface

interface pwmfd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pwmfd_pkg::CFG_IDX_W-1:0]  index;
	logic [pwmfd_pkg::DUR_W-1:0]      data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/pulse_width_manchester_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// pulse_width_manchester_frame_decoder
// Turns timed line segments into half-bits and decodes 34-bit Manchester frames.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                      | transfer when
//  seg     | in  | segment_level, segment_duration, frame_end   | valid & ready
//  frame   | out | frame_word, frame_status                     | valid & ready
//  cfg     | in  | index, data                                  | valid & ready
//
//  One segment per cycle while seg.ready is high; a frame_end segment's result is
//  offered after it passes the input register, snapshot stage and result register,
//  the two register stages after the input register.
//  arst_n loads the register reset values and clears half-bit capture, count and sticky error.
//  A stalled result holds the decode stage; plain segments keep flowing until
//  the next frame_end reaches the input register. cfg is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pulse_width_manchester_frame_decoder_assert.svh"

module pulse_width_manchester_frame_decoder (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pwmfd_seg_if.sink     seg,
	pwmfd_frame_if.source frame,
	pwmfd_cfg_if.sink     cfg
);

	// Configuration
	logic [pwmfd_pkg::DUR_W-1:0]   hmin_q, hmax_q, fmin_q, fmax_q;
	logic                          slave_q;

	// Input register
	logic                          valid_s1;
	logic                          lvl_s1;
	logic [pwmfd_pkg::DUR_W-1:0]   dur_s1;
	logic                          fend_s1;
	logic                          adv_s1;

	// Frame capture state
	logic [pwmfd_pkg::HALF_N-1:0]  sr_q, sr_nx;
	logic [pwmfd_pkg::CNT_W-1:0]   cnt_q, cnt_nx, cnt_sum;
	logic [1:0]                    sticky_q, err_nx;
	logic                          in_half, in_full;

	logic                          dec_ready;
	pwmfd_pkg::snap_t              snap;

	assign cfg.ready = 1'b1;
	assign adv_s1    = valid_s1 && (!fend_s1 || dec_ready);
	assign seg.ready = !valid_s1 || adv_s1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hmin_q  <= pwmfd_pkg::HALF_MIN_RST;
			hmax_q  <= pwmfd_pkg::HALF_MAX_RST;
			fmin_q  <= pwmfd_pkg::FULL_MIN_RST;
			fmax_q  <= pwmfd_pkg::FULL_MAX_RST;
			slave_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pwmfd_pkg::REG_HALF_MIN: hmin_q  <= cfg.data;
				pwmfd_pkg::REG_HALF_MAX: hmax_q  <= cfg.data;
				pwmfd_pkg::REG_FULL_MIN: fmin_q  <= cfg.data;
				pwmfd_pkg::REG_FULL_MAX: fmax_q  <= cfg.data;
				pwmfd_pkg::REG_SLAVE:    slave_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (seg.ready) begin
			valid_s1 <= seg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seg.ready && seg.valid) begin
			lvl_s1  <= seg.segment_level;
			dur_s1  <= seg.segment_duration;
			fend_s1 <= seg.frame_end;
		end
	end

	// Segment classification and half-bit shift-in
	assign in_half = (dur_s1 >= hmin_q) && (dur_s1 <= hmax_q);
	assign in_full = (dur_s1 >= fmin_q) && (dur_s1 <= fmax_q);
	assign cnt_sum = cnt_q + (in_half ? pwmfd_pkg::CNT_W'(1) : pwmfd_pkg::CNT_W'(2));

	always_comb begin
		sr_nx  = sr_q;
		cnt_nx = cnt_q;
		err_nx = sticky_q;
		if (sticky_q == pwmfd_pkg::ERR_NONE && dur_s1 != '0) begin
			if (!in_half && !in_full) begin
				err_nx = (dur_s1 < hmin_q) ? pwmfd_pkg::ERR_GLITCH : pwmfd_pkg::ERR_TIMING;
			end else if (cnt_sum > pwmfd_pkg::CNT_W'(pwmfd_pkg::HALF_N)) begin
				err_nx = pwmfd_pkg::ERR_TIMING;
			end else if (in_half) begin
				sr_nx  = {sr_q[pwmfd_pkg::HALF_N-2:0], lvl_s1};
				cnt_nx = cnt_sum;
			end else begin
				sr_nx  = {sr_q[pwmfd_pkg::HALF_N-3:0], lvl_s1, lvl_s1};
				cnt_nx = cnt_sum;
			end
		end
	end

	assign snap.sr  = sr_nx;
	assign snap.cnt = cnt_nx;
	assign snap.err = err_nx;

	// Capture state; cleared after every frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q     <= '0;
			cnt_q    <= '0;
			sticky_q <= pwmfd_pkg::ERR_NONE;
		end else if (adv_s1) begin
			if (fend_s1) begin
				sr_q     <= '0;
				cnt_q    <= '0;
				sticky_q <= pwmfd_pkg::ERR_NONE;
			end else begin
				sr_q     <= sr_nx;
				cnt_q    <= cnt_nx;
				sticky_q <= err_nx;
			end
		end
	end

	pwmfd_dec u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_in    (snap),
		.load       (adv_s1 && fend_s1),
		.slave_side (slave_q),
		.can_load   (dec_ready),
		.frame      (frame)
	);

	// Checks
	`PWMFD_ASSERT_ALWAYS(a_cnt_range, cnt_q <= pwmfd_pkg::CNT_W'(pwmfd_pkg::HALF_N))
	`PWMFD_ASSERT_ALWAYS(a_err_code, sticky_q <= pwmfd_pkg::ERR_TIMING)
	`PWMFD_ASSERT_NEXT(a_frame_clear, adv_s1 && fend_s1, cnt_q == '0 && sticky_q == pwmfd_pkg::ERR_NONE)
	`PWMFD_ASSERT_NEXT(a_err_sticks, adv_s1 && !fend_s1 && sticky_q != pwmfd_pkg::ERR_NONE, sticky_q == $past(sticky_q) && cnt_q == $past(cnt_q))

endmodule

`default_nettype wire

@@ design/pwmfd_dec.sv @@
// ----------------------------------------------------------------------------
// pwmfd_dec
// Frame decode stage: salvage, realign, Manchester decode, checks, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwmfd_dec (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pwmfd_pkg::snap_t snap_in,
	input  wire logic             load,
	input  wire logic             slave_side,
	output logic                  can_load,
	pwmfd_frame_if.source         frame
);

	logic                              valid_s2;
	pwmfd_pkg::snap_t                  snap_s2;
	logic                              valid_q;
	logic [pwmfd_pkg::DATA_BITS-1:0]   word_q;
	logic [2:0]                        status_q;
	logic                              adv_s2;

	logic [pwmfd_pkg::HALF_N-1:0]      al;
	logic                              al_ok;
	logic [pwmfd_pkg::HALF_N-1:0]      hb;
	logic [pwmfd_pkg::FRAME_BITS-1:0]  pbit;
	logic [pwmfd_pkg::FRAME_BITS-1:0]  pbad;
	logic [pwmfd_pkg::DATA_BITS-1:0]   word;
	logic [pwmfd_pkg::DATA_BITS-1:0]   word_d;
	logic [2:0]                        status_d;
	logic                              type_bad;

	// Handshake between snapshot stage and result register
	assign adv_s2   = valid_s2 && (!valid_q || frame.ready);
	assign can_load = !valid_s2 || adv_s2;

	assign frame.valid        = valid_q;
	assign frame.frame_word   = word_q;
	assign frame.frame_status = status_q;

	// Salvage a one-short capture and align to 68 half-bits, first in MSB
	always_comb begin
		al    = snap_s2.sr;
		al_ok = 1'b0;
		if (snap_s2.cnt == pwmfd_pkg::CNT_W'(pwmfd_pkg::HALF_N)) begin
			al_ok = 1'b1;
		end else if (snap_s2.cnt == pwmfd_pkg::CNT_W'(pwmfd_pkg::HALF_N - 1)) begin
			if (snap_s2.sr[pwmfd_pkg::HALF_N-2]) begin
				// leading zero: the unused top bit is already clear
				al_ok = 1'b1;
			end else if (!snap_s2.sr[0]) begin
				al    = {snap_s2.sr[pwmfd_pkg::HALF_N-2:0], 1'b1};
				al_ok = 1'b1;
			end
		end
	end

	// Shift forward one place, invert, tail keeps the last bit uninverted
	assign hb = {~al[pwmfd_pkg::HALF_N-2:0], al[0]};

	// Manchester pairs: 01 is a one, 10 is a zero
	always_comb begin
		for (int i = 0; i < pwmfd_pkg::FRAME_BITS; i++) begin
			pbit[i] = !hb[pwmfd_pkg::HALF_N-1-2*i] && hb[pwmfd_pkg::HALF_N-2-2*i];
			pbad[i] = hb[pwmfd_pkg::HALF_N-1-2*i] == hb[pwmfd_pkg::HALF_N-2-2*i];
		end
		for (int j = 0; j < pwmfd_pkg::DATA_BITS; j++) begin
			word[j] = pbit[pwmfd_pkg::FRAME_BITS-2-j];
		end
	end

	// Message type check on bits 30:29 of the word
	assign type_bad = slave_side ? (word[pwmfd_pkg::TYPE_LSB+1 -: 2] != 2'b00)
	                             : (word[pwmfd_pkg::TYPE_LSB+1 -: 2] != 2'b10);

	// Status priority
	always_comb begin
		word_d   = '0;
		status_d = pwmfd_pkg::ST_OK;
		if (snap_s2.err != pwmfd_pkg::ERR_NONE) begin
			status_d = (snap_s2.err == pwmfd_pkg::ERR_GLITCH) ? pwmfd_pkg::ST_GLITCH
			                                                   : pwmfd_pkg::ST_TIMING;
		end else if (!al_ok) begin
			status_d = pwmfd_pkg::ST_TIMING;
		end else if (pbad[0] || !pbit[0]) begin
			status_d = pwmfd_pkg::ST_START;
		end else if ((|pbad[pwmfd_pkg::FRAME_BITS-1:1]) ||
		             !pbit[pwmfd_pkg::FRAME_BITS-1]) begin
			status_d = pwmfd_pkg::ST_TIMING;
		end else begin
			word_d = word;
			if (^word) begin
				status_d = pwmfd_pkg::ST_PARITY;
			end else if (type_bad) begin
				status_d = pwmfd_pkg::ST_TYPE;
			end
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				valid_q <= 1'b1;
			end else if (frame.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			snap_s2 <= snap_in;
		end
		if (adv_s2) begin
			word_q   <= word_d;
			status_q <= status_d;
		end
	end

endmodule

`default_nettype wire
